FILE: hw/rtl/b32d_pkg.sv
package b32d_pkg;

    localparam int unsigned CHARS     = 8;
    localparam int unsigned CHAR_W    = 8;
    localparam int unsigned SYM_W     = 5;
    localparam int unsigned BYTES     = 5;
    localparam int unsigned GROUP_W   = CHARS * SYM_W;
    localparam int unsigned CNT_W     = 3;
    localparam int unsigned PAD_W     = 4;
    localparam int unsigned IN_DATA_W = CHARS * CHAR_W;
    localparam int unsigned OUT_DATA_W = 48;

    localparam logic [CHAR_W-1:0] PAD_CHAR     = 8'h3D;
    localparam logic [CHAR_W-1:0] UPPER_A      = 8'h41;
    localparam logic [CHAR_W-1:0] UPPER_Z      = 8'h5A;
    localparam logic [CHAR_W-1:0] LOWER_A      = 8'h61;
    localparam logic [CHAR_W-1:0] LOWER_Z      = 8'h7A;
    localparam logic [CHAR_W-1:0] DIGIT_2      = 8'h32;
    localparam logic [CHAR_W-1:0] DIGIT_7      = 8'h37;
    localparam logic [CHAR_W-1:0] DIGIT_OFFSET = 8'd26;

    localparam logic [CNT_W-1:0] BYTES_FOR_CHARS [0:CHARS] =
        '{3'd0, 3'd0, 3'd1, 3'd0, 3'd2, 3'd3, 3'd0, 3'd4, 3'd5};

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_CHAR   = 2'd1,
        ST_BAD_PAD    = 2'd2,
        ST_SUPPRESSED = 2'd3
    } t_status;

    typedef struct packed {
        logic             ok;
        logic [SYM_W-1:0] val;
    } t_sym;

    typedef struct packed {
        logic [GROUP_W-1:0] group;
        logic [CNT_W-1:0]   nbytes;
        t_status            status;
        logic               last;
    } t_cls;

    function automatic t_sym sym_value(input logic [CHAR_W-1:0] c);
        t_sym s;
        logic [CHAR_W-1:0] d;
        s = '0;
        d = '0;
        if (c >= UPPER_A && c <= UPPER_Z) begin
            d = c - UPPER_A;
            s = '{ok: 1'b1, val: d[SYM_W-1:0]};
        end else if (c >= LOWER_A && c <= LOWER_Z) begin
            d = c - LOWER_A;
            s = '{ok: 1'b1, val: d[SYM_W-1:0]};
        end else if (c >= DIGIT_2 && c <= DIGIT_7) begin
            d = c - DIGIT_2 + DIGIT_OFFSET;
            s = '{ok: 1'b1, val: d[SYM_W-1:0]};
        end
        return s;
    endfunction

endpackage

FILE: hw/rtl/b32d_front.sv
module b32d_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [b32d_pkg::IN_DATA_W-1:0] i_s_axis_tdata,
    input  logic                          i_s_axis_tlast,
    output logic                          o_push,
    output b32d_pkg::t_cls                o_cls,
    input  logic                          i_full
);
    import b32d_pkg::*;

    logic              r_valid;
    t_cls              r_cls;
    t_cls              n_cls;
    logic              take;
    logic              run;
    logic [PAD_W-1:0]  pad;
    logic [PAD_W-1:0]  nvalid;
    logic              char_err;
    t_sym              sym;

    // pad run, symbol decode and error class for one block
    always_comb begin
        run      = i_s_axis_tlast;
        pad      = '0;
        char_err = 1'b0;
        sym      = '0;
        n_cls    = '0;
        for (int i = 0; i < CHARS; i++) begin
            if (run && i_s_axis_tdata[(CHARS-1-i)*CHAR_W +: CHAR_W] == PAD_CHAR) begin
                pad = pad + 1'b1;
            end else begin
                run = 1'b0;
            end
        end
        nvalid = PAD_W'(CHARS) - pad;
        for (int i = 0; i < CHARS; i++) begin
            sym = sym_value(i_s_axis_tdata[i*CHAR_W +: CHAR_W]);
            if (PAD_W'(i) < nvalid) begin
                n_cls.group[GROUP_W-1-i*SYM_W -: SYM_W] = sym.val;
                if (!sym.ok) begin
                    char_err = 1'b1;
                end
            end
        end
        n_cls.nbytes = BYTES_FOR_CHARS[nvalid];
        n_cls.last   = i_s_axis_tlast;
        if (n_cls.nbytes == '0) begin
            n_cls.status = ST_BAD_PAD;
        end else if (char_err) begin
            n_cls.status = ST_BAD_CHAR;
        end else begin
            n_cls.status = ST_OK;
        end
    end

    assign o_push          = r_valid && !i_full;
    assign o_s_axis_tready = !r_valid || !i_full;
    assign take            = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cls           = r_cls;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cls <= n_cls;
        end
    end

endmodule

FILE: hw/rtl/b32d_fifo.sv
module b32d_fifo #(
    parameter int unsigned DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  b32d_pkg::t_cls i_cls,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output b32d_pkg::t_cls o_cls
);
    import b32d_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_FW = $clog2(DEPTH + 1);

    t_cls              r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_FW-1:0] r_count;
    logic              wr;
    logic              rd;

    assign o_full  = r_count == CNT_FW'(DEPTH);
    assign o_valid = r_count != '0;
    assign o_cls   = r_mem[r_rd_ptr];
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (rd) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (wr && !rd) begin
                r_count <= r_count + 1'b1;
            end else if (rd && !wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wr_ptr] <= i_cls;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FW'(DEPTH))
        else $error("queue count above depth");

    a_count_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr && !rd) |=> r_count == $past(r_count) + 1'b1)
        else $error("queue count lost a write");

endmodule

FILE: hw/rtl/b32d_back.sv
module b32d_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  b32d_pkg::t_cls                  i_cls,
    output logic                            o_pop,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [b32d_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    output logic [1:0]                      o_m_axis_tuser,
    output logic                            o_m_axis_tlast
);
    import b32d_pkg::*;

    logic                    r_err_seen;
    logic                    r_m_valid;
    logic [BYTES*8-1:0]      r_bytes;
    logic [CNT_W-1:0]        r_count;
    t_status                 r_status;
    logic                    r_last;
    logic [BYTES*8-1:0]      n_bytes;
    logic [CNT_W-1:0]        n_count;
    t_status                 n_status;

    assign o_pop = i_valid && (!r_m_valid || i_m_axis_tready);

    // byte i is the top-aligned slice of the group, zero beyond the count or when the status is not ok
    always_comb begin
        n_bytes  = '0;
        n_count  = '0;
        n_status = r_err_seen ? ST_SUPPRESSED : i_cls.status;
        if (n_status == ST_OK) begin
            n_count = i_cls.nbytes;
            for (int i = 0; i < BYTES; i++) begin
                if (CNT_W'(i) < i_cls.nbytes) begin
                    n_bytes[i*8 +: 8] = i_cls.group[GROUP_W-1-i*8 -: 8];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err_seen <= 1'b0;
            r_m_valid  <= 1'b0;
        end else begin
            if (o_pop) begin
                r_m_valid  <= 1'b1;
                r_err_seen <= !i_cls.last && (n_status != ST_OK);
            end else if (i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_bytes  <= n_bytes;
            r_count  <= n_count;
            r_status <= n_status;
            r_last   <= i_cls.last;
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = {{(OUT_DATA_W - BYTES*8 - CNT_W){1'b0}}, r_count, r_bytes};
    assign o_m_axis_tuser  = r_status;
    assign o_m_axis_tlast  = r_last;

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && r_status != ST_OK) |-> (r_count == '0 && r_bytes == '0))
        else $error("error result carries data");

    a_ok_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && r_status == ST_OK) |-> r_count != '0)
        else $error("ok result without bytes");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_cls.last) |=> !r_err_seen)
        else $error("error flag survived end of message");

endmodule

FILE: hw/rtl/base32_block_decoder.sv
// channel   | direction | tdata                                  | tuser      | tlast
// s_axis    | in        | char0..char7, 8 bits each              | -          | msg_last
// m_axis    | out       | byte0..byte4, byte_count, 5 zero bits  | status     | message_end
//
// one block per cycle sustained while m_axis does not stall; an accepted block passes
// through the input register, the queue and the output register on its way to m_axis
// reset clears the error flag, the queue and both valid registers
// a stalled m_axis fills the queue; s_axis tready drops once the queue and
// the input register are both full
module base32_block_decoder #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,   // char0 .. char7
    input  logic        i_s_axis_tlast,   // msg_last
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,   // byte0 .. byte4, byte_count, zero fill
    output logic [1:0]  o_m_axis_tuser,   // status
    output logic        o_m_axis_tlast    // message_end
);
    import b32d_pkg::*;

    logic push;
    logic full;
    logic pop;
    logic q_valid;
    t_cls front_cls;
    t_cls q_cls;

    b32d_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_push          (push),
        .o_cls           (front_cls),
        .i_full          (full)
    );

    b32d_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cls   (front_cls),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cls   (q_cls)
    );

    b32d_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (q_valid),
        .i_cls           (q_cls),
        .o_pop           (pop),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

endmodule

FILE: verif/tb_base32_block_decoder.sv
`timescale 1ns / 1ps

module tb_base32_block_decoder;
    import b32d_pkg::*;

    localparam int N_DIRECTED  = 25;
    localparam int N_RANDOM    = 780;
    localparam int LONG_STALL  = 60;
    localparam int DRAIN_WAIT  = 20;

    typedef logic [0:CHARS-1][CHAR_W-1:0] t_block;

    typedef struct packed {
        logic [0:BYTES-1][7:0] bytes;
        logic [CNT_W-1:0]      cnt;
        t_status               st;
        logic                  msg_end;
    } t_result;

    typedef struct packed {
        t_block                text;
        logic                  last;
        logic                  typed;
        logic [0:BYTES-1][7:0] bytes;
        logic [CNT_W-1:0]      cnt;
        t_status               st;
    } t_row;

    // text, last, typed, bytes, count, status
    localparam t_row DIRECTED [N_DIRECTED] = '{
        '{"AAAAAAAA", 1'b0, 1'b1, 40'h0,          3'd5, ST_OK},
        '{"77777777", 1'b0, 1'b1, 40'hFFFFFFFFFF, 3'd5, ST_OK},
        '{"zzzzzzzz", 1'b1, 1'b0, 40'h0,          3'd0, ST_OK},
        '{"abcdefgh", 1'b0, 1'b0, 40'h0,          3'd0, ST_OK},
        '{"ABCDEFGH", 1'b1, 1'b0, 40'h0,          3'd0, ST_OK},
        '{"MZXW6===", 1'b1, 1'b1, 40'h666F6F0000, 3'd3, ST_OK},
        '{"MY======", 1'b1, 1'b1, 40'h6600000000, 3'd1, ST_OK},
        '{"MZXQ====", 1'b1, 1'b1, 40'h666F000000, 3'd2, ST_OK},
        '{"MZXW6YQ=", 1'b1, 1'b0, 40'h0,          3'd0, ST_OK},
        '{"77======", 1'b1, 1'b0, 40'h0,          3'd0, ST_OK},
        '{"AAAAAA==", 1'b1, 1'b1, 40'h0,          3'd0, ST_BAD_PAD},
        '{"AAA=====", 1'b1, 1'b1, 40'h0,          3'd0, ST_BAD_PAD},
        '{"A=======", 1'b1, 1'b1, 40'h0,          3'd0, ST_BAD_PAD},
        '{"========", 1'b1, 1'b1, 40'h0,          3'd0, ST_BAD_PAD},
        '{"A@AAAA==", 1'b1, 1'b1, 40'h0,          3'd0, ST_BAD_PAD},
        '{"AAAA=AAA", 1'b0, 1'b1, 40'h0,          3'd0, ST_BAD_CHAR},
        '{"AAAAAAAA", 1'b0, 1'b1, 40'h0,          3'd0, ST_SUPPRESSED},
        '{"MY======", 1'b1, 1'b1, 40'h0,          3'd0, ST_SUPPRESSED},
        '{"AA=A====", 1'b1, 1'b1, 40'h0,          3'd0, ST_BAD_CHAR},
        '{{"@[", 8'h60, "{18", 8'h00, 8'hFF}, 1'b1, 1'b1, 40'h0, 3'd0, ST_BAD_CHAR},
        '{"2Zaz7AZa", 1'b1, 1'b0, 40'h0,          3'd0, ST_OK},
        '{"AAAAAAA[", 1'b0, 1'b1, 40'h0,          3'd0, ST_BAD_CHAR},
        '{"AAAAAAAA", 1'b1, 1'b1, 40'h0,          3'd0, ST_SUPPRESSED},
        '{"AAAAAAAA", 1'b1, 1'b1, 40'h0,          3'd5, ST_OK},
        '{{"ABCDEFG", 8'h80}, 1'b1, 1'b1, 40'h0,   3'd0, ST_BAD_CHAR}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [63:0] i_s_axis_tdata;   // char0 .. char7
    logic        i_s_axis_tlast;   // msg_last
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [47:0] o_m_axis_tdata;   // byte0 .. byte4, byte_count, zero fill
    logic [1:0]  o_m_axis_tuser;   // status
    logic        o_m_axis_tlast;   // message_end

    t_result decode_fifo [$];
    logic    msg_err_seen;
    logic    tx_quiet;
    logic    rx_quiet;
    logic    long_stall_req;
    int      n_blocks;
    int      n_msgs;
    int      n_checked;
    int      n_failed_blocks;
    int      n_suppressed;
    int      mismatches;

    base32_block_decoder dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #10 i_clk = ~i_clk;

    function automatic logic sym_of(input logic [7:0] c, output logic [SYM_W-1:0] v);
        v = '0;
        if (c >= "A" && c <= "Z") begin
            v = SYM_W'(c - "A");
            return 1'b1;
        end
        if (c >= "a" && c <= "z") begin
            v = SYM_W'(c - "a");
            return 1'b1;
        end
        if (c >= "2" && c <= "7") begin
            v = SYM_W'(c - "2" + 26);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic int bytes_from_chars(input int n);
        case (n)
            8: return 5;
            7: return 4;
            5: return 3;
            4: return 2;
            2: return 1;
            default: return 0;
        endcase
    endfunction

    // updates the per-message error flag as the block goes by
    function automatic t_result decode_block(input t_block blk, input logic last);
        t_result          r;
        int               pads;
        int               nchar;
        int               nb;
        logic [GROUP_W-1:0] grp;
        logic [SYM_W-1:0] v;
        t_status          st;
        r = '0;
        r.msg_end = last;
        st = ST_OK;
        pads = 0;
        grp = '0;
        if (msg_err_seen) begin
            st = ST_SUPPRESSED;
        end else begin
            if (last) begin
                while (pads < CHARS && blk[CHARS-1-pads] == PAD_CHAR) pads++;
            end
            nchar = CHARS - pads;
            nb = bytes_from_chars(nchar);
            if (nb == 0) begin
                st = ST_BAD_PAD;
            end else begin
                for (int i = 0; i < nchar; i++) begin
                    if (st == ST_OK) begin
                        if (!sym_of(blk[i], v)) st = ST_BAD_CHAR;
                        grp = {grp[GROUP_W-SYM_W-1:0], v};
                    end
                end
            end
            if (st == ST_OK) begin
                grp = grp << (SYM_W * (CHARS - nchar));
                for (int i = 0; i < nb; i++) r.bytes[i] = grp[GROUP_W-1-8*i -: 8];
                r.cnt = CNT_W'(nb);
            end else begin
                msg_err_seen = 1'b1;
            end
        end
        r.st = st;
        if (last) msg_err_seen = 1'b0;
        return r;
    endfunction

    function automatic logic [7:0] rand_sym();
        int k;
        k = $urandom_range(0, 31);
        if (k >= 26) return DIGIT_2 + 8'(k - 26);
        return ($urandom_range(0, 1) ? LOWER_A : UPPER_A) + 8'(k);
    endfunction

    // starts and ends on a falling edge
    task automatic send_block(input t_block blk, input logic last, input logic typed,
                              input t_result typed_r);
        int      gap;
        t_result r;
        gap = tx_quiet ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            i_s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        for (int i = 0; i < CHARS; i++) i_s_axis_tdata[8*i +: 8] = blk[i];
        i_s_axis_tlast  = last;
        i_s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!o_s_axis_tready);
        r = decode_block(blk, last);
        decode_fifo.push_back(typed ? typed_r : r);
        n_blocks++;
        if (last) n_msgs++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_s_axis_tvalid = 1'b0;
        while (decode_fifo.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_message();
        int     nblk;
        int     pads;
        logic   last;
        t_block blk;
        nblk = $urandom_range(1, 4);
        for (int b = 0; b < nblk; b++) begin
            last = (b == nblk - 1);
            if ($urandom_range(0, 15) == 0) begin
                // pure noise block
                for (int i = 0; i < CHARS; i++) blk[i] = 8'($urandom_range(0, 255));
                last = $urandom_range(0, 1);
            end else begin
                for (int i = 0; i < CHARS; i++) blk[i] = rand_sym();
                if (last) begin
                    if ($urandom_range(0, 6) == 0) begin
                        case ($urandom_range(0, 3))
                            0: pads = 2;
                            1: pads = 5;
                            2: pads = 7;
                            default: pads = 8;
                        endcase
                    end else begin
                        case ($urandom_range(0, 4))
                            0: pads = 0;
                            1: pads = 1;
                            2: pads = 3;
                            3: pads = 4;
                            default: pads = 6;
                        endcase
                    end
                    for (int i = CHARS - pads; i < CHARS; i++) blk[i] = PAD_CHAR;
                end
                if ($urandom_range(0, 9) == 0)
                    blk[$urandom_range(0, CHARS-1)] = 8'($urandom_range(0, 255));
                if ($urandom_range(0, 19) == 0) blk[$urandom_range(0, CHARS-1)] = PAD_CHAR;
            end
            send_block(blk, last, 1'b0, '0);
            if (last) break;
        end
    endtask

    // result side: per-result stall, plus one long hold-off on request
    initial begin
        int stall;
        i_m_axis_tready = 1'b0;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            if (long_stall_req) begin
                long_stall_req  = 1'b0;
                i_m_axis_tready = 1'b0;
                repeat (LONG_STALL) @(negedge i_clk);
            end
            stall = rx_quiet ? 0 : $urandom_range(0, 15);
            if (stall > 0) begin
                i_m_axis_tready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_m_axis_tready = 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid);
            @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (decode_fifo.size() == 0) begin
                $error("result with no block pending");
                mismatches++;
            end else begin
                want = decode_fifo.pop_front();
                n_checked++;
                if (want.st == ST_BAD_CHAR || want.st == ST_BAD_PAD) n_failed_blocks++;
                if (want.st == ST_SUPPRESSED) n_suppressed++;
                for (int i = 0; i < BYTES; i++) begin
                    if (o_m_axis_tdata[8*i +: 8] !== want.bytes[i]) begin
                        $error("byte%0d: expected %h, got %h", i, want.bytes[i],
                               o_m_axis_tdata[8*i +: 8]);
                        mismatches++;
                    end
                end
                if (o_m_axis_tdata[8*BYTES +: CNT_W] !== want.cnt) begin
                    $error("byte_count: expected %0d, got %0d", want.cnt,
                           o_m_axis_tdata[8*BYTES +: CNT_W]);
                    mismatches++;
                end
                if (o_m_axis_tuser !== want.st) begin
                    $error("status: expected %0d, got %0d", want.st, o_m_axis_tuser);
                    mismatches++;
                end
                if (o_m_axis_tlast !== want.msg_end) begin
                    $error("message_end: expected %0d, got %0d", want.msg_end,
                           o_m_axis_tlast);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        #10ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        t_result typed_r;
        int      phase;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tlast  = 1'b0;
        msg_err_seen    = 1'b0;
        tx_quiet        = 1'b0;
        rx_quiet        = 1'b0;
        long_stall_req  = 1'b0;
        n_blocks        = 0;
        n_msgs          = 0;
        n_checked       = 0;
        n_failed_blocks = 0;
        n_suppressed    = 0;
        mismatches      = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int k = 0; k < N_DIRECTED; k++) begin
            typed_r.bytes   = DIRECTED[k].bytes;
            typed_r.cnt     = DIRECTED[k].cnt;
            typed_r.st      = DIRECTED[k].st;
            typed_r.msg_end = DIRECTED[k].last;
            send_block(DIRECTED[k].text, DIRECTED[k].last, DIRECTED[k].typed, typed_r);
        end
        drain();

        phase = 0;
        while (n_blocks < N_DIRECTED + N_RANDOM) begin
            if (phase == 2) begin
                // back-to-back requests against a stalled output
                tx_quiet = 1'b1;
                rx_quiet = 1'b0;
                long_stall_req = 1'b1;
                repeat (8) send_message();
            end else begin
                tx_quiet = ($urandom_range(0, 3) == 0);
                rx_quiet = ($urandom_range(0, 3) == 0);
                repeat (30) send_message();
            end
            if ($urandom_range(0, 1)) drain();
            phase++;
        end
        i_s_axis_tvalid = 1'b0;
        rx_quiet = 1'b0;
        while (decode_fifo.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("sent %0d blocks in %0d messages, checked %0d results", n_blocks, n_msgs,
                 n_checked);
        $display("%0d blocks failed decode, %0d suppressed behind an earlier error",
                 n_failed_blocks, n_suppressed);
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
